// ===== src/tagged_hash_history_compare_defines.svh =====
// assertion helpers, need clk and rst_n in scope
`ifndef TAGGED_HASH_HISTORY_COMPARE_DEFINES_SVH
`define TAGGED_HASH_HISTORY_COMPARE_DEFINES_SVH

// same-cycle implication
`define THC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define THC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/thc_pkg.sv =====
package thc_pkg;

  localparam int HISTORY_DEPTH  = 64;
  localparam int CATEGORY_COUNT = 6;
  localparam int HIST_AW        = $clog2(HISTORY_DEPTH);
  localparam int HASH_W         = 32;
  localparam int TICK_W         = 32;
  localparam int TIME_W         = 48;
  localparam int CFG_IW         = 3;
  localparam int CFG_DW         = 24;

  localparam logic [1:0] MODE_STORE   = 2'd0;
  localparam logic [1:0] MODE_COMPARE = 2'd1;
  localparam logic [1:0] MODE_CLEAR   = 2'd2;

  localparam logic [CFG_IW-1:0] REG_ENABLE      = 3'd0;
  localparam logic [CFG_IW-1:0] REG_CAT_MASK    = 3'd1;
  localparam logic [CFG_IW-1:0] REG_AUTHORITY   = 3'd2;
  localparam logic [CFG_IW-1:0] REG_REPORT_CD   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_BUNDLE_CD   = 3'd4;

  localparam logic [CATEGORY_COUNT-1:0] CAT_MASK_RST  = 6'h3F;
  localparam logic [15:0]               REPORT_CD_RST = 16'd250;
  localparam logic [23:0]               BUNDLE_CD_RST = 24'd60000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CMP
  } state_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [TICK_W-1:0] tick;
    logic [HASH_W-1:0] hash_players;
    logic [HASH_W-1:0] hash_sectors;
    logic [HASH_W-1:0] hash_movers;
    logic [HASH_W-1:0] hash_actors;
    logic [HASH_W-1:0] hash_rng;
    logic [HASH_W-1:0] hash_linespec;
    logic [TIME_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic                      found;
    logic [CATEGORY_COUNT-1:0] mismatch_mask;
    logic                      emit_trace;
    logic                      emit_bundle;
  } out_item_t;

  typedef logic [CATEGORY_COUNT-1:0][HASH_W-1:0] hash_row_t;

  function automatic hash_row_t item_hashes(input in_item_t it);
    hash_row_t h;
    h[0] = it.hash_players;
    h[1] = it.hash_sectors;
    h[2] = it.hash_movers;
    h[3] = it.hash_actors;
    h[4] = it.hash_rng;
    h[5] = it.hash_linespec;
    return h;
  endfunction

endpackage

// ===== src/tagged_hash_history_compare.sv =====
// Tick-tagged history of category hashes with remote compare.
// Input channel in_valid/in_stall/in_data: mode store, compare or clear.
// Result channel out_valid/out_stall/out_data: one result per compare
// transfer taken while enabled and not authority; stores, clears and
// ignored items give none.
// Config port cfg_we/cfg_index/cfg_wdata: write only, while idle.
// Stores and clears do not stall the input; a new item can follow every cycle while no compare is in progress.
// Compare scans the tick memory from slot 0, one read per cycle on its
// single read port, up to the first hit or through the last slot on a
// miss, then loads the result. in_stall is high until the result is loaded.
// Reset (synchronous, rst_n low): ring empty, write slot 0, no last tick,
// cooldown stamps at never, registers at their defaults.
// When the receiver stalls, the result waits in the output register;
// stores and clears are still taken, and a following compare holds in
// its last step until the output register frees.
`include "tagged_hash_history_compare_defines.svh"

module tagged_hash_history_compare (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  thc_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output thc_pkg::out_item_t               out_data,
  input  logic                             cfg_we,
  input  logic [thc_pkg::CFG_IW-1:0]       cfg_index,
  input  logic [thc_pkg::CFG_DW-1:0]       cfg_wdata
);
  import thc_pkg::*;

  localparam logic [HIST_AW-1:0] HIST_LAST = HIST_AW'(HISTORY_DEPTH - 1);

  logic                      enable_r;
  logic [CATEGORY_COUNT-1:0] cat_mask_r;
  logic                      authority_r;
  logic [15:0]               report_cd_r;
  logic [23:0]               bundle_cd_r;

  state_t                    state_r, state_nxt;
  in_item_t                  req_r, req_nxt;
  logic [HIST_AW-1:0]        scan_idx_r, scan_idx_nxt;
  logic [HIST_AW-1:0]        rd_idx_r, rd_idx_nxt;
  logic                      rd_pend_r, rd_pend_nxt;
  logic                      found_r, found_nxt;
  logic [HISTORY_DEPTH-1:0]  valid_r, valid_nxt;
  logic [HIST_AW-1:0]        write_slot_r, write_slot_nxt;
  logic                      last_valid_r, last_valid_nxt;
  logic [TICK_W-1:0]         last_tick_r, last_tick_nxt;
  logic [TIME_W-1:0]         report_stamp_r, report_stamp_nxt;
  logic [TIME_W-1:0]         bundle_stamp_r, bundle_stamp_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_item_t                 out_data_r, out_data_nxt;

  logic [TICK_W-1:0]         tick_mem [HISTORY_DEPTH];
  hash_row_t                 hash_mem [HISTORY_DEPTH];
  logic [TICK_W-1:0]         tick_q_r;
  hash_row_t                 hash_q_r;

  logic                      in_xfer;
  logic                      mem_we;
  hash_row_t                 wr_row;
  logic                      scan_hit;
  logic                      out_load;
  logic [CATEGORY_COUNT-1:0] mism;
  logic [TIME_W-1:0]         report_age, bundle_age;
  logic                      report_pass, bundle_pass;

  assign in_xfer   = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b1;
      cat_mask_r  <= CAT_MASK_RST;
      authority_r <= 1'b0;
      report_cd_r <= REPORT_CD_RST;
      bundle_cd_r <= BUNDLE_CD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE:    enable_r    <= cfg_wdata[0];
        REG_CAT_MASK:  cat_mask_r  <= cfg_wdata[CATEGORY_COUNT-1:0];
        REG_AUTHORITY: authority_r <= cfg_wdata[0];
        REG_REPORT_CD: report_cd_r <= cfg_wdata[15:0];
        REG_BUNDLE_CD: bundle_cd_r <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  // store row with disabled categories zeroed
  always_comb begin
    hash_row_t h;
    h = item_hashes(in_data);
    for (int i = 0; i < CATEGORY_COUNT; i++) begin
      wr_row[i] = cat_mask_r[i] ? h[i] : '0;
    end
  end

  assign mem_we = in_xfer && (in_data.mode == MODE_STORE) && enable_r &&
                  !(last_valid_r && (last_tick_r == in_data.tick));

  // history memories
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tick_mem[write_slot_r] <= in_data.tick;
    end
    tick_q_r <= tick_mem[scan_idx_r];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hash_mem[write_slot_r] <= wr_row;
    end
    hash_q_r <= hash_mem[rd_idx_r];
  end

  assign scan_hit = rd_pend_r && valid_r[rd_idx_r] && (tick_q_r == req_r.tick);

  // compare and cooldowns
  always_comb begin
    hash_row_t h;
    h = item_hashes(req_r);
    for (int i = 0; i < CATEGORY_COUNT; i++) begin
      mism[i] = found_r && cat_mask_r[i] && (h[i] != hash_q_r[i]);
    end
  end

  assign report_age  = req_r.now_ms - report_stamp_r;
  assign bundle_age  = req_r.now_ms - bundle_stamp_r;
  assign report_pass = (report_stamp_r == '0) || (report_age >= TIME_W'(report_cd_r));
  assign bundle_pass = (bundle_stamp_r == '0) || (bundle_age >= TIME_W'(bundle_cd_r));
  assign out_load    = (state_r == ST_CMP) && !(out_valid_r && out_stall);

  always_comb begin
    state_nxt        = state_r;
    req_nxt          = req_r;
    scan_idx_nxt     = scan_idx_r;
    rd_idx_nxt       = rd_idx_r;
    rd_pend_nxt      = rd_pend_r;
    found_nxt        = found_r;
    valid_nxt        = valid_r;
    write_slot_nxt   = write_slot_r;
    last_valid_nxt   = last_valid_r;
    last_tick_nxt    = last_tick_r;
    report_stamp_nxt = report_stamp_r;
    bundle_stamp_nxt = bundle_stamp_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_data_nxt     = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (in_data.mode)
            MODE_CLEAR: begin
              valid_nxt        = '0;
              write_slot_nxt   = '0;
              last_valid_nxt   = 1'b0;
              report_stamp_nxt = '0;
              bundle_stamp_nxt = '0;
            end
            MODE_STORE: begin
              if (mem_we) begin
                valid_nxt[write_slot_r] = 1'b1;
                write_slot_nxt = (write_slot_r == HIST_LAST) ? '0 : write_slot_r + 1'b1;
                last_valid_nxt = 1'b1;
                last_tick_nxt  = in_data.tick;
              end
            end
            MODE_COMPARE: begin
              if (enable_r && !authority_r) begin
                req_nxt      = in_data;
                scan_idx_nxt = '0;
                rd_pend_nxt  = 1'b0;
                state_nxt    = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        scan_idx_nxt = scan_idx_r + 1'b1;
        rd_idx_nxt   = scan_idx_r;
        rd_pend_nxt  = 1'b1;
        if (scan_hit) begin
          rd_idx_nxt = rd_idx_r;
          found_nxt  = 1'b1;
          state_nxt  = ST_CMP;
        end else if (rd_pend_r && (rd_idx_r == HIST_LAST)) begin
          rd_idx_nxt = rd_idx_r;
          found_nxt  = 1'b0;
          state_nxt  = ST_CMP;
        end
      end
      ST_CMP: begin
        if (out_load) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.found         = found_r;
          out_data_nxt.mismatch_mask = mism;
          out_data_nxt.emit_trace    = (mism != '0) && report_pass;
          out_data_nxt.emit_bundle   = (mism != '0) && bundle_pass;
          if ((mism != '0) && report_pass) begin
            report_stamp_nxt = req_r.now_ms;
          end
          if ((mism != '0) && bundle_pass) begin
            bundle_stamp_nxt = req_r.now_ms;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      rd_pend_r      <= 1'b0;
      found_r        <= 1'b0;
      valid_r        <= '0;
      write_slot_r   <= '0;
      last_valid_r   <= 1'b0;
      report_stamp_r <= '0;
      bundle_stamp_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      rd_pend_r      <= rd_pend_nxt;
      found_r        <= found_nxt;
      valid_r        <= valid_nxt;
      write_slot_r   <= write_slot_nxt;
      last_valid_r   <= last_valid_nxt;
      report_stamp_r <= report_stamp_nxt;
      bundle_stamp_r <= bundle_stamp_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    scan_idx_r  <= scan_idx_nxt;
    rd_idx_r    <= rd_idx_nxt;
    last_tick_r <= last_tick_nxt;
    out_data_r  <= out_data_nxt;
  end

  `THC_ASSERT_NEXT(a_hit_goes_cmp, (state_r == ST_SCAN) && scan_hit, (state_r == ST_CMP) && found_r, "scan hit did not reach compare step")
  `THC_ASSERT_NEXT(a_miss_clean, out_load && !found_r, (out_data_r.mismatch_mask == '0) && !out_data_r.emit_trace && !out_data_r.emit_bundle, "miss result carries flags")
  `THC_ASSERT_NOW(a_emit_needs_mism, out_valid_r && (out_data_r.emit_trace || out_data_r.emit_bundle), out_data_r.mismatch_mask != '0, "emit flag without mismatch")

endmodule

// ===== verif/tb_tagged_hash_history_compare.sv =====
`default_nettype none

module tb_tagged_hash_history_compare;
  timeunit 1ns;
  timeprecision 1ps;

  import thc_pkg::*;

  localparam logic [1:0]        MODE_UNUSED   = 2'd3;
  localparam logic [CFG_IW-1:0] REG_NONE_LO   = 3'd5;
  localparam logic [CFG_IW-1:0] REG_NONE_HI   = 3'd7;
  localparam int                CYCLE_LIMIT   = 800000;
  localparam int                DRAIN_LIMIT   = 5000;
  localparam int                SETTLE_CYCLES = 80;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_RUNS} stall_style_t;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                cfg_we    = 1'b0;
  logic [CFG_IW-1:0]   cfg_index = '0;
  logic [CFG_DW-1:0]   cfg_wdata = '0;

  // register copies
  logic                      shadow_enable    = 1'b1;
  logic [CATEGORY_COUNT-1:0] shadow_cat_mask  = CAT_MASK_RST;
  logic                      shadow_authority = 1'b0;
  logic [15:0]               shadow_report_cd = REPORT_CD_RST;
  logic [23:0]               shadow_bundle_cd = BUNDLE_CD_RST;

  // history copy
  logic [TICK_W-1:0] ring_tick  [HISTORY_DEPTH];
  logic              ring_valid [HISTORY_DEPTH];
  logic [HASH_W-1:0] ring_hash  [HISTORY_DEPTH][CATEGORY_COUNT];
  logic [HIST_AW-1:0] next_slot;
  logic               have_last_tick;
  logic [TICK_W-1:0]  last_tick;
  logic [TIME_W-1:0]  trace_stamp;
  logic [TIME_W-1:0]  bundle_stamp;

  in_item_t  snapshot_queue[$];
  out_item_t awaited_verdicts[$];
  in_item_t  recent_stores[$];
  logic [TICK_W-1:0] gen_tick = '0;
  logic [TIME_W-1:0] gen_now  = 48'd1000;

  int queued_count   = 0;
  int taken_count    = 0;
  int fail_count     = 0;
  int checked_count  = 0;
  int hits_seen      = 0;
  int traces_seen    = 0;
  int bundles_seen   = 0;
  int settings_count = 0;
  int cycle_count    = 0;
  int burst_left     = 0;
  int gap_left       = 0;
  int stall_left     = 0;
  int style_age      = 0;
  stall_style_t stall_style = STALL_NONE;
  out_item_t want_result;

  tagged_hash_history_compare u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // category 0 (players) sits just below the tick
  function automatic int cat_lsb(input int k);
    return TIME_W + HASH_W * (CATEGORY_COUNT - 1 - k);
  endfunction

  function automatic logic [HASH_W-1:0] category_hash(input in_item_t it, input int k);
    return it[cat_lsb(k) +: HASH_W];
  endfunction

  function automatic logic cooldown_open(input logic [TIME_W-1:0] stamp,
                                         input logic [TIME_W-1:0] now,
                                         input logic [CFG_DW-1:0] span);
    logic [TIME_W-1:0] elapsed;
    elapsed = now - stamp;
    return (stamp == '0) || (elapsed >= TIME_W'(span));
  endfunction

  task automatic forget_history();
    for (int k = 0; k < HISTORY_DEPTH; k++) begin
      ring_valid[k] = 1'b0;
      ring_tick[k]  = '0;
      for (int c = 0; c < CATEGORY_COUNT; c++) ring_hash[k][c] = '0;
    end
    next_slot      = '0;
    have_last_tick = 1'b0;
    last_tick      = '0;
    trace_stamp    = '0;
    bundle_stamp   = '0;
  endtask

  task automatic judge_snapshot(input in_item_t it);
    logic [CATEGORY_COUNT-1:0] diff;
    logic                      hit_found;
    int                        hit_slot;
    out_item_t                 verdict;
    diff      = '0;
    hit_found = 1'b0;
    hit_slot  = 0;
    verdict   = '0;
    if (it.mode == MODE_CLEAR) begin
      forget_history();
      return;
    end
    if (it.mode == MODE_UNUSED || !shadow_enable) return;
    if (it.mode == MODE_STORE) begin
      if (have_last_tick && last_tick == it.tick) return;
      ring_tick[next_slot]  = it.tick;
      ring_valid[next_slot] = 1'b1;
      for (int c = 0; c < CATEGORY_COUNT; c++)
        ring_hash[next_slot][c] = shadow_cat_mask[c] ? category_hash(it, c) : '0;
      next_slot      = next_slot + 1'b1;
      have_last_tick = 1'b1;
      last_tick      = it.tick;
      return;
    end
    if (shadow_authority) return;
    // lowest slot wins on duplicate ticks
    for (int k = 0; k < HISTORY_DEPTH; k++) begin
      if (!hit_found && ring_valid[k] && ring_tick[k] == it.tick) begin
        hit_found = 1'b1;
        hit_slot  = k;
      end
    end
    if (hit_found) begin
      for (int c = 0; c < CATEGORY_COUNT; c++)
        diff[c] = shadow_cat_mask[c] && (category_hash(it, c) != ring_hash[hit_slot][c]);
      if (diff != '0) begin
        verdict.emit_trace  = cooldown_open(trace_stamp, it.now_ms, CFG_DW'(shadow_report_cd));
        verdict.emit_bundle = cooldown_open(bundle_stamp, it.now_ms, shadow_bundle_cd);
        if (verdict.emit_trace) trace_stamp = it.now_ms;
        if (verdict.emit_bundle) bundle_stamp = it.now_ms;
      end
    end
    verdict.found         = hit_found;
    verdict.mismatch_mask = diff;
    awaited_verdicts.push_back(verdict);
  endtask

  function automatic in_item_t snapshot(input logic [1:0] op, input logic [TICK_W-1:0] tick,
                                        input logic [HASH_W-1:0] fill,
                                        input logic [TIME_W-1:0] now);
    in_item_t it;
    it.mode = op;
    it.tick = tick;
    for (int c = 0; c < CATEGORY_COUNT; c++) it[cat_lsb(c) +: HASH_W] = fill;
    it.now_ms = now;
    return it;
  endfunction

  function automatic in_item_t random_snapshot();
    in_item_t          it;
    int unsigned       pick;
    logic [TIME_W-1:0] stamp_now;
    pick = $urandom_range(99);
    it = snapshot(MODE_COMPARE, $urandom, $urandom, {16'($urandom), $urandom});
    for (int c = 0; c < CATEGORY_COUNT; c++) it[cat_lsb(c) +: HASH_W] = $urandom;
    case ($urandom_range(9))
      0, 1, 2, 3: gen_now += $urandom_range(400);
      4, 5, 6:    gen_now += $urandom_range(70000);
      7:          gen_now += $urandom_range(20000000);
      8:          gen_now = {16'($urandom), $urandom};
      default:    ;
    endcase
    stamp_now = ($urandom_range(49) == 0) ? '0 : gen_now;
    if (pick < 40) begin
      it.mode = MODE_STORE;
      case ($urandom_range(9))
        0:       ;  // same tick again, should be skipped
        1:       gen_tick = $urandom;
        default: gen_tick = gen_tick + 1'b1;
      endcase
      it.tick = gen_tick;
      recent_stores.push_back(it);
      if (recent_stores.size() > 96) void'(recent_stores.pop_front());
    end else if (pick < 86 && recent_stores.size() != 0) begin
      it = recent_stores[$urandom_range(recent_stores.size() - 1)];
      it.mode = MODE_COMPARE;
      it.now_ms = stamp_now;
      if ($urandom_range(1) == 1) begin
        for (int c = 0; c < CATEGORY_COUNT; c++)
          if ($urandom_range(3) == 0) it[cat_lsb(c) + int'($urandom_range(31))] ^= 1'b1;
      end
    end else if (pick < 94) begin
      it.mode = MODE_COMPARE;
      it.now_ms = stamp_now;
    end else if (pick < 95) begin
      it.mode = MODE_CLEAR;
    end else begin
      it.mode = MODE_UNUSED;
    end
    return it;
  endfunction

  task automatic enqueue(input in_item_t it);
    snapshot_queue.push_back(it);
    queued_count++;
  endtask

  task automatic queue_random(input int count);
    repeat (count) enqueue(random_snapshot());
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    while (taken_count != queued_count) @(posedge clk);
    while (awaited_verdicts.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (awaited_verdicts.size() != 0) begin
      fail_count++;
      $display("%0t ns: %0d compare results never arrived", $time, awaited_verdicts.size());
      awaited_verdicts.delete();
    end
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    settings_count++;
    case (idx)
      REG_ENABLE:    shadow_enable    = value[0];
      REG_CAT_MASK:  shadow_cat_mask  = value[CATEGORY_COUNT-1:0];
      REG_AUTHORITY: shadow_authority = value[0];
      REG_REPORT_CD: shadow_report_cd = value[15:0];
      REG_BUNDLE_CD: shadow_bundle_cd = value;
      default:       ;
    endcase
  endtask

  task automatic check_field(input string field, input int unsigned want, input int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // input driver, bursts with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        judge_snapshot(in_data);
        taken_count++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (snapshot_queue.size() != 0) begin
          in_data  <= snapshot_queue.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(24);
            case ($urandom_range(3))
              0:       gap_left = 0;
              1:       gap_left = $urandom_range(1, 3);
              2:       gap_left = $urandom_range(4, 12);
              default: gap_left = $urandom_range(13, 40);
            endcase
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result checker and receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_verdicts.size() == 0) begin
          fail_count++;
          $display("%0t ns: unexpected result, expected none, actual found %0b mask %02h",
                   $time, out_data.found, out_data.mismatch_mask);
        end else begin
          want_result = awaited_verdicts.pop_front();
          checked_count++;
          hits_seen    += int'(out_data.found);
          traces_seen  += int'(out_data.emit_trace);
          bundles_seen += int'(out_data.emit_bundle);
          check_field("found", want_result.found, out_data.found);
          check_field("mismatch_mask", want_result.mismatch_mask, out_data.mismatch_mask);
          check_field("emit_trace", want_result.emit_trace, out_data.emit_trace);
          check_field("emit_bundle", want_result.emit_bundle, out_data.emit_bundle);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        style_age++;
        if (style_age >= 300) begin
          style_age   = 0;
          stall_style = stall_style_t'($urandom_range(3));
        end
        case (stall_style)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(7) == 0);
          STALL_HALF:  out_stall <= ($urandom_range(1) == 1);
          default: begin
            if ($urandom_range(15) == 0) begin
              stall_left = $urandom_range(4, 20);
              out_stall <= 1'b1;
            end else begin
              out_stall <= 1'b0;
            end
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    in_item_t item;
    forget_history();

    // directed part
    enqueue(snapshot(MODE_COMPARE, 32'd0, 32'd0, 48'd5));           // empty ring
    enqueue(snapshot(MODE_STORE, 32'd0, 32'd0, 48'd0));
    enqueue(snapshot(MODE_STORE, 32'd0, 32'h1234_5678, 48'd0));     // repeated tick
    enqueue(snapshot(MODE_STORE, '1, '1, 48'd0));
    enqueue(snapshot(MODE_COMPARE, 32'd0, 32'd0, 48'd10));
    item = snapshot(MODE_COMPARE, '1, '1, 48'd0);
    item.hash_linespec[31] = 1'b0;
    enqueue(item);                                                    // now zero keeps never
    item.now_ms = 48'd100;
    enqueue(item);
    item.now_ms = 48'd200;
    enqueue(item);
    item.now_ms = 48'd350;
    enqueue(item);
    enqueue(snapshot(MODE_COMPARE, '1, 32'd0, '1));
    enqueue(snapshot(MODE_COMPARE, '1, 32'd0, 48'h10));              // time wraps
    enqueue(snapshot(MODE_STORE, 32'd5, 32'hA5A5_A5A5, 48'd0));
    enqueue(snapshot(MODE_STORE, 32'd6, 32'h5A5A_5A5A, 48'd0));
    enqueue(snapshot(MODE_STORE, 32'd5, 32'h0F0F_0F0F, 48'd0));
    enqueue(snapshot(MODE_COMPARE, 32'd5, 32'hA5A5_A5A5, 48'h2_0000)); // lowest slot wins
    item = snapshot(MODE_COMPARE, 32'd6, 32'h5A5A_5A5A, 48'h3_0000);
    item.hash_players[0] = ~item.hash_players[0];
    enqueue(item);
    enqueue(snapshot(MODE_UNUSED, '0, '1, '1));
    enqueue(snapshot(MODE_CLEAR, '1, '0, '0));
    enqueue(snapshot(MODE_COMPARE, 32'd0, 32'd0, 48'h4_0000));
    enqueue(snapshot(MODE_COMPARE, 32'd5, 32'hA5A5_A5A5, 48'h4_0001));
    enqueue(snapshot(MODE_STORE, 32'd7, 32'hC3C3_C3C3, 48'd0));
    enqueue(snapshot(MODE_CLEAR, '0, '1, '1));
    enqueue(snapshot(MODE_STORE, 32'd7, 32'hC3C3_C3C3, 48'd0));     // last tick forgotten
    item = snapshot(MODE_COMPARE, 32'd7, 32'hC3C3_C3C3, 48'h3_0001);
    item.hash_rng = ~item.hash_rng;
    enqueue(item);                                                    // stamps reset by clear

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    queue_random(170);
    wait_drained();

    write_reg(REG_CAT_MASK, CFG_DW'($urandom_range(1, 62)));
    write_reg(REG_REPORT_CD, '0);
    write_reg(REG_BUNDLE_CD, '0);
    cfg_we <= 1'b0;
    queue_random(170);
    wait_drained();

    write_reg(REG_CAT_MASK, '0);
    write_reg(REG_REPORT_CD, CFG_DW'(16'hFFFF));
    write_reg(REG_BUNDLE_CD, 24'hFF_FFFF);
    write_reg(REG_NONE_LO, CFG_DW'($urandom));
    cfg_we <= 1'b0;
    queue_random(60);
    wait_drained();

    write_reg(REG_CAT_MASK, CFG_DW'(CAT_MASK_RST));
    write_reg(REG_AUTHORITY, CFG_DW'(1));
    write_reg(REG_NONE_HI, CFG_DW'($urandom));
    cfg_we <= 1'b0;
    queue_random(80);
    wait_drained();

    write_reg(REG_AUTHORITY, '0);
    write_reg(REG_ENABLE, '0);
    cfg_we <= 1'b0;
    queue_random(80);
    wait_drained();

    write_reg(REG_ENABLE, CFG_DW'(1));
    write_reg(REG_CAT_MASK, CFG_DW'($urandom_range(63)));
    write_reg(REG_REPORT_CD, CFG_DW'($urandom_range(65535)));
    write_reg(REG_BUNDLE_CD, CFG_DW'($urandom_range(16777215)));
    cfg_we <= 1'b0;
    queue_random(260);
    wait_drained();

    write_reg(REG_CAT_MASK, CFG_DW'(CAT_MASK_RST));
    write_reg(REG_REPORT_CD, CFG_DW'(16'hFFFF));
    write_reg(REG_BUNDLE_CD, 24'hFF_FFFF);
    cfg_we <= 1'b0;
    queue_random(260);
    wait_drained();

    $display("sent %0d snapshots over %0d register writes; checked %0d compares", taken_count,
             settings_count, checked_count);
    $display("  of which %0d hits, %0d traces, %0d bundles", hits_seen, traces_seen,
             bundles_seen);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
